[hdl/aftc_pkg.sv]
// Shared types, register map and sequencer step function for the flash trigger controller.
// Used by every module under hdl/; depends on nothing else.
package aftc_pkg;

    // Item kinds on the input channel
    typedef enum logic [1:0] {
        REQ_TICK = 2'd0,
        REQ_BG   = 2'd1,
        REQ_DET  = 2'd2,
        REQ_NONE = 2'd3
    } t_req;

    // Converter sampling mode
    typedef enum logic [1:0] {
        MODE_BG  = 2'd0,
        MODE_DET = 2'd1,
        MODE_OFF = 2'd2
    } t_mode;

    // Shutter sequencer phases
    typedef enum logic [2:0] {
        PH_STARTUP  = 3'd0,
        PH_INITLOCK = 3'd1,
        PH_IDLE     = 3'd2,
        PH_SHOT     = 3'd3,
        PH_SETTLE   = 3'd4,
        PH_LOCK     = 3'd5,
        PH_RELOCK   = 3'd6
    } t_phase;

    // Register indexes on the APB port
    typedef enum logic [2:0] {
        REG_LOCKUP_EN = 3'd0,
        REG_REFRESH   = 3'd1,
        REG_MARGIN    = 3'd2,
        REG_PULSE     = 3'd3,
        REG_SETTLE    = 3'd4,
        REG_STARTUP   = 3'd5,
        REG_RELOCK    = 3'd6
    } t_reg_idx;

    localparam int CFG_ADDR_W  = 5;
    localparam int APB_DATA_W  = 32;
    localparam int LIMIT_BITS  = 10;
    localparam int MARGIN_BITS = 10;
    localparam int TICK_BITS   = 16;
    localparam int AVG_SAMPLES = 8;
    localparam int AVG_LOG2    = 3;
    // Worst case chain: startup, init lock, idle, shot, settle, lock, idle, relock, idle
    localparam int NUM_STEPS   = 8;

    localparam logic [LIMIT_BITS-1:0]  THRESHOLD_RST    = 10'd1023;
    localparam logic [TICK_BITS-1:0]   RST_REFRESH      = 16'd5000;
    localparam logic [MARGIN_BITS-1:0] RST_MARGIN       = 10'd5;
    localparam logic [TICK_BITS-1:0]   RST_PULSE        = 16'd100;
    localparam logic [TICK_BITS-1:0]   RST_SETTLE       = 16'd2000;
    localparam logic [TICK_BITS-1:0]   RST_STARTUP      = 16'd1000;
    localparam logic [TICK_BITS-1:0]   RST_RELOCK       = 16'd30500;

    typedef struct packed {
        logic                   lockup_enable;
        logic [TICK_BITS-1:0]   refresh_interval;
        logic [MARGIN_BITS-1:0] margin;
        logic [TICK_BITS-1:0]   pulse_ticks;
        logic [TICK_BITS-1:0]   settle_ticks;
        logic [TICK_BITS-1:0]   startup_ticks;
        logic [TICK_BITS-1:0]   relock_timeout;
    } t_cfg;

    // Startup reload event from a write to the startup register
    typedef struct packed {
        logic                 startup_wr;
        logic [TICK_BITS-1:0] value;
    } t_cfg_evt;

    // Sequencer and mode state touched by the shutter sequence
    typedef struct packed {
        t_phase               phase;
        logic [TICK_BITS-1:0] timer;
        logic [TICK_BITS-1:0] relock_cnt;
        logic                 relock_req;
        logic                 pending;
        logic                 shutter;
        t_mode                mode;
    } t_seq;

    typedef struct packed {
        logic                  shutter;
        logic                  want_channel;
        logic                  converter_on;
        logic [LIMIT_BITS-1:0] level_limit;
        logic                  fired;
        logic                  busy;
    } t_result;

    // One sequencer transition; a settled state maps onto itself
    function automatic t_seq seq_step(input t_seq s, input t_cfg c);
        t_seq n;
        n = s;
        unique case (s.phase)
            PH_STARTUP: begin
                if (s.timer == '0) begin
                    if (c.lockup_enable) begin
                        n.phase   = PH_INITLOCK;
                        n.shutter = 1'b1;
                        n.timer   = c.pulse_ticks;
                    end else begin
                        n.phase = PH_IDLE;
                    end
                end
            end
            PH_INITLOCK: begin
                if (s.timer == '0) begin
                    n.shutter = 1'b0;
                    n.phase   = PH_IDLE;
                end
            end
            PH_SHOT: begin
                if (s.timer == '0) begin
                    n.shutter = 1'b0;
                    if (c.lockup_enable) begin
                        n.phase = PH_SETTLE;
                        n.timer = c.settle_ticks;
                    end else begin
                        n.pending = 1'b0;
                        n.phase   = PH_IDLE;
                        if (s.mode == MODE_OFF) begin
                            n.mode = MODE_DET;
                        end
                    end
                end
            end
            PH_SETTLE: begin
                if (s.timer == '0) begin
                    n.phase   = PH_LOCK;
                    n.shutter = 1'b1;
                    n.timer   = c.pulse_ticks;
                end
            end
            PH_LOCK: begin
                if (s.timer == '0) begin
                    n.shutter    = 1'b0;
                    n.relock_cnt = c.relock_timeout;
                    n.pending    = 1'b0;
                    n.phase      = PH_IDLE;
                    if (s.mode == MODE_OFF) begin
                        n.mode = MODE_DET;
                    end
                end
            end
            PH_RELOCK: begin
                if (s.timer == '0) begin
                    n.shutter    = 1'b0;
                    n.relock_cnt = c.relock_timeout;
                    n.phase      = PH_IDLE;
                end
            end
            default: begin
                // Idle: serve a pending shot first, then a re-lock request
                n.phase = PH_IDLE;
                if (s.pending) begin
                    n.phase   = PH_SHOT;
                    n.shutter = 1'b1;
                    n.timer   = c.pulse_ticks;
                end else if (c.lockup_enable && s.relock_req) begin
                    n.relock_req = 1'b0;
                    n.phase      = PH_RELOCK;
                    n.shutter    = 1'b1;
                    n.timer      = c.pulse_ticks;
                end
            end
        endcase
        return n;
    endfunction

endpackage

[hdl/aftc_cfg.sv]
// APB register file for the flash trigger controller settings.
// Depends on aftc_pkg for the register map, reset values and the t_cfg struct.
module aftc_cfg (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [aftc_pkg::CFG_ADDR_W-1:0]     paddr,
    input  logic [aftc_pkg::APB_DATA_W-1:0]     pwdata,
    output logic [aftc_pkg::APB_DATA_W-1:0]     prdata,
    output logic                                pready,
    output aftc_pkg::t_cfg                      o_cfg,
    output aftc_pkg::t_cfg_evt                  o_cfg_evt
);

    aftc_pkg::t_cfg     r_cfg;
    aftc_pkg::t_reg_idx idx;
    logic               wr;

    assign pready = 1'b1;
    assign idx    = aftc_pkg::t_reg_idx'(paddr[aftc_pkg::CFG_ADDR_W-1:2]);
    assign wr     = psel && penable && pwrite;

    // Flag a startup write so the sequencer can reload its wait
    assign o_cfg_evt.startup_wr = wr && (idx == aftc_pkg::REG_STARTUP);
    assign o_cfg_evt.value      = pwdata[aftc_pkg::TICK_BITS-1:0];
    assign o_cfg                = r_cfg;

    // Write registers on the access beat
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.lockup_enable    <= 1'b0;
            r_cfg.refresh_interval <= aftc_pkg::RST_REFRESH;
            r_cfg.margin           <= aftc_pkg::RST_MARGIN;
            r_cfg.pulse_ticks      <= aftc_pkg::RST_PULSE;
            r_cfg.settle_ticks     <= aftc_pkg::RST_SETTLE;
            r_cfg.startup_ticks    <= aftc_pkg::RST_STARTUP;
            r_cfg.relock_timeout   <= aftc_pkg::RST_RELOCK;
        end else if (wr) begin
            unique case (idx)
                aftc_pkg::REG_LOCKUP_EN: r_cfg.lockup_enable <= pwdata[0];
                aftc_pkg::REG_REFRESH: begin
                    r_cfg.refresh_interval <= pwdata[aftc_pkg::TICK_BITS-1:0];
                end
                aftc_pkg::REG_MARGIN: r_cfg.margin <= pwdata[aftc_pkg::MARGIN_BITS-1:0];
                aftc_pkg::REG_PULSE: r_cfg.pulse_ticks <= pwdata[aftc_pkg::TICK_BITS-1:0];
                aftc_pkg::REG_SETTLE: r_cfg.settle_ticks <= pwdata[aftc_pkg::TICK_BITS-1:0];
                aftc_pkg::REG_STARTUP: begin
                    r_cfg.startup_ticks <= pwdata[aftc_pkg::TICK_BITS-1:0];
                end
                aftc_pkg::REG_RELOCK: begin
                    r_cfg.relock_timeout <= pwdata[aftc_pkg::TICK_BITS-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    // Read back the addressed register
    always_comb begin
        prdata = '0;
        unique case (idx)
            aftc_pkg::REG_LOCKUP_EN: prdata = aftc_pkg::APB_DATA_W'(r_cfg.lockup_enable);
            aftc_pkg::REG_REFRESH:   prdata = aftc_pkg::APB_DATA_W'(r_cfg.refresh_interval);
            aftc_pkg::REG_MARGIN:    prdata = aftc_pkg::APB_DATA_W'(r_cfg.margin);
            aftc_pkg::REG_PULSE:     prdata = aftc_pkg::APB_DATA_W'(r_cfg.pulse_ticks);
            aftc_pkg::REG_SETTLE:    prdata = aftc_pkg::APB_DATA_W'(r_cfg.settle_ticks);
            aftc_pkg::REG_STARTUP:   prdata = aftc_pkg::APB_DATA_W'(r_cfg.startup_ticks);
            aftc_pkg::REG_RELOCK:    prdata = aftc_pkg::APB_DATA_W'(r_cfg.relock_timeout);
            default:                 prdata = '0;
        endcase
    end

endmodule

[hdl/aftc_adv.sv]
// Sequencer settle chain: applies the step function until the shutter sequence rests.
// Depends on aftc_pkg for t_seq, t_cfg and seq_step.
module aftc_adv (
    input  aftc_pkg::t_seq i_seq,
    input  aftc_pkg::t_cfg i_cfg,
    output aftc_pkg::t_seq o_seq
);

    aftc_pkg::t_seq chain [aftc_pkg::NUM_STEPS+1];

    assign chain[0] = i_seq;

    // Cascade fixed transitions; zero-length waits fall through in the same beat
    for (genvar k = 0; k < aftc_pkg::NUM_STEPS; k++) begin : g_step
        assign chain[k+1] = aftc_pkg::seq_step(chain[k], i_cfg);
    end

    assign o_seq = chain[aftc_pkg::NUM_STEPS];

endmodule

[hdl/aftc_core.sv]
// Controller state: background averaging, threshold, detection, tick timers and sequencer.
// Depends on aftc_pkg and instantiates aftc_adv.
module aftc_core #(
    parameter int SAMPLE_BITS = 10
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_step,
    input  aftc_pkg::t_req         i_req_type,
    input  logic [SAMPLE_BITS-1:0] i_sample,
    input  aftc_pkg::t_cfg         i_cfg,
    input  aftc_pkg::t_cfg_evt     i_cfg_evt,
    output aftc_pkg::t_result      o_res
);

    localparam int CNT_W = aftc_pkg::AVG_LOG2;
    localparam int ACC_W = SAMPLE_BITS + aftc_pkg::AVG_LOG2;
    localparam int LIM_W = (SAMPLE_BITS > aftc_pkg::LIMIT_BITS) ? SAMPLE_BITS
                                                                 : aftc_pkg::LIMIT_BITS;
    localparam int LVL_W = LIM_W + 1;
    localparam logic [SAMPLE_BITS-1:0] SAMPLE_MAX = {SAMPLE_BITS{1'b1}};
    localparam logic [LIM_W-1:0] TH_RST_W = LIM_W'(SAMPLE_MAX) &
                                            LIM_W'(aftc_pkg::THRESHOLD_RST);
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(aftc_pkg::AVG_SAMPLES - 1);

    aftc_pkg::t_seq           r_seq;
    logic [aftc_pkg::TICK_BITS-1:0] r_refresh;
    logic [ACC_W-1:0]         r_acc;
    logic [CNT_W-1:0]         r_cnt;
    logic [SAMPLE_BITS-1:0]   r_threshold;

    aftc_pkg::t_seq           n_seq_pre;
    aftc_pkg::t_seq           n_seq;
    logic [aftc_pkg::TICK_BITS-1:0] n_refresh;
    logic [ACC_W-1:0]         n_acc;
    logic [CNT_W-1:0]         n_cnt;
    logic [SAMPLE_BITS-1:0]   n_threshold;
    logic                     fired;

    logic [ACC_W-1:0]         acc_sum;
    logic [SAMPLE_BITS-1:0]   avg;
    logic [LVL_W-1:0]         lvl;
    logic [LIM_W-1:0]         th_wide;

    // Average of the completed window plus margin
    assign acc_sum = r_acc + ACC_W'(i_sample);
    assign avg     = acc_sum[ACC_W-1:aftc_pkg::AVG_LOG2];
    assign lvl     = LVL_W'(avg) + LVL_W'(i_cfg.margin);

    // Apply the item to the state ahead of the sequencer
    always_comb begin
        n_seq_pre   = r_seq;
        n_refresh   = r_refresh;
        n_acc       = r_acc;
        n_cnt       = r_cnt;
        n_threshold = r_threshold;
        fired       = 1'b0;
        unique case (i_req_type)
            aftc_pkg::REQ_TICK: begin
                if (r_seq.timer != '0) begin
                    n_seq_pre.timer = r_seq.timer - 1'b1;
                end
                if (r_seq.relock_cnt != '0) begin
                    n_seq_pre.relock_cnt = r_seq.relock_cnt - 1'b1;
                    if (r_seq.relock_cnt == aftc_pkg::TICK_BITS'(1)) begin
                        n_seq_pre.relock_req = 1'b1;
                    end
                end
                if (r_refresh > i_cfg.refresh_interval) begin
                    n_refresh      = '0;
                    n_seq_pre.mode = aftc_pkg::MODE_BG;
                    n_acc          = '0;
                    n_cnt          = '0;
                end else begin
                    n_refresh = r_refresh + 1'b1;
                end
            end
            aftc_pkg::REQ_BG: begin
                if (r_seq.mode == aftc_pkg::MODE_BG) begin
                    if (r_cnt == CNT_LAST) begin
                        n_threshold = (lvl > LVL_W'(SAMPLE_MAX)) ? SAMPLE_MAX
                                                                 : lvl[SAMPLE_BITS-1:0];
                        n_acc          = '0;
                        n_cnt          = '0;
                        n_seq_pre.mode = aftc_pkg::MODE_DET;
                    end else begin
                        n_acc = acc_sum;
                        n_cnt = r_cnt + 1'b1;
                    end
                end
            end
            aftc_pkg::REQ_DET: begin
                if (r_seq.mode == aftc_pkg::MODE_DET && i_sample > r_threshold &&
                    !r_seq.pending) begin
                    n_seq_pre.shutter = 1'b1;
                    n_seq_pre.mode    = aftc_pkg::MODE_OFF;
                    n_seq_pre.pending = 1'b1;
                    fired             = 1'b1;
                end
            end
            default: begin
            end
        endcase
    end

    aftc_adv u_adv (
        .i_seq (n_seq_pre),
        .i_cfg (i_cfg),
        .o_seq (n_seq)
    );

    // Format the result beat from the settled state
    always_comb begin
        th_wide            = LIM_W'(n_threshold);
        o_res.shutter      = n_seq.shutter;
        o_res.want_channel = (n_seq.mode != aftc_pkg::MODE_BG);
        o_res.converter_on = (n_seq.mode != aftc_pkg::MODE_OFF);
        o_res.level_limit  = th_wide[aftc_pkg::LIMIT_BITS-1:0];
        o_res.fired        = fired;
        o_res.busy         = n_seq.pending || (n_seq.phase != aftc_pkg::PH_IDLE);
    end

    // Commit each processed beat; else a startup write reloads the wait during startup
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seq.phase      <= aftc_pkg::PH_STARTUP;
            r_seq.timer      <= aftc_pkg::RST_STARTUP;
            r_seq.relock_cnt <= '0;
            r_seq.relock_req <= 1'b0;
            r_seq.pending    <= 1'b0;
            r_seq.shutter    <= 1'b0;
            r_seq.mode       <= aftc_pkg::MODE_BG;
            r_refresh        <= '0;
            r_acc            <= '0;
            r_cnt            <= '0;
            r_threshold      <= TH_RST_W[SAMPLE_BITS-1:0];
        end else if (i_step) begin
            r_seq       <= n_seq;
            r_refresh   <= n_refresh;
            r_acc       <= n_acc;
            r_cnt       <= n_cnt;
            r_threshold <= n_threshold;
        end else if (i_cfg_evt.startup_wr && r_seq.phase == aftc_pkg::PH_STARTUP) begin
            r_seq.timer <= i_cfg_evt.value;
        end
    end

endmodule

[hdl/adaptive_flash_trigger_controller.sv]
// Top level of the adaptive flash trigger controller: handshake stages and assertions.
// Depends on aftc_pkg and instantiates aftc_cfg and aftc_core.
//
// Usage: the input channel (i_valid, o_stall, i_req_type, i_sample) carries one
// item per beat: a millisecond tick, a background sample or a detector sample.
// The output channel (o_valid, i_stall) returns exactly one result beat per item,
// in order: shutter level, wanted converter channel, converter enable, current
// threshold, a fired flag for the detecting sample and a busy flag.
// An accepted item waits in an input register until the result register is free,
// then its result is formed and captured in the output register. One item per
// cycle is taken while the receiver does not stall; the whole update (average,
// threshold, detect and the sequencer's fall-through of zero-length waits) sits
// between those two registers. When the receiver stalls, the result stays put and
// the input register still takes one more item; o_stall rises only when both
// stages hold a beat. The user is to write settings over APB only while no item
// is in flight; the block itself does not enforce it. Reset empties both stages,
// loads the default settings, sets the threshold to full scale (1023 at most)
// and starts the startup wait; there is no clearing pass.
module adaptive_flash_trigger_controller #(
    parameter int SAMPLE_BITS = 10
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // Item channel
    input  logic                                i_valid,
    output logic                                o_stall,
    input  logic [1:0]                          i_req_type,
    input  logic [SAMPLE_BITS-1:0]              i_sample,
    // Result channel
    output logic                                o_valid,
    input  logic                                i_stall,
    output logic                                o_shutter,
    output logic                                o_want_channel,
    output logic                                o_converter_on,
    output logic [aftc_pkg::LIMIT_BITS-1:0]     o_level_limit,
    output logic                                o_fired,
    output logic                                o_busy_res,
    // Configuration
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [aftc_pkg::CFG_ADDR_W-1:0]     paddr,
    input  logic [aftc_pkg::APB_DATA_W-1:0]     pwdata,
    output logic [aftc_pkg::APB_DATA_W-1:0]     prdata,
    output logic                                pready
);

    aftc_pkg::t_cfg      cfg;
    aftc_pkg::t_cfg_evt  cfg_evt;
    aftc_pkg::t_result   res;

    logic                   r_in_valid;
    aftc_pkg::t_req         r_in_type;
    logic [SAMPLE_BITS-1:0] r_in_sample;
    logic                   r_out_valid;
    aftc_pkg::t_result      r_out;

    logic                   n_in_valid;
    logic                   n_out_valid;
    logic                   out_free;
    logic                   move;
    logic                   accept;

    aftc_cfg u_cfg (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready),
        .o_cfg     (cfg),
        .o_cfg_evt (cfg_evt)
    );

    aftc_core #(
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_core (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_step     (move),
        .i_req_type (r_in_type),
        .i_sample   (r_in_sample),
        .i_cfg      (cfg),
        .i_cfg_evt  (cfg_evt),
        .o_res      (res)
    );

    // Advance the input beat when the result register is empty or draining
    assign out_free    = !r_out_valid || !i_stall;
    assign move        = r_in_valid && out_free;
    assign o_stall     = r_in_valid && !out_free;
    assign accept      = i_valid && !o_stall;
    assign n_in_valid  = accept || (r_in_valid && !move);
    assign n_out_valid = move || (r_out_valid && i_stall);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_in_valid  <= n_in_valid;
            r_out_valid <= n_out_valid;
        end
    end

    // Capture payloads; no reset needed
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_in_type   <= aftc_pkg::t_req'(i_req_type);
            r_in_sample <= i_sample;
        end
        if (move) begin
            r_out <= res;
        end
    end

    assign o_valid        = r_out_valid;
    assign o_shutter      = r_out.shutter;
    assign o_want_channel = r_out.want_channel;
    assign o_converter_on = r_out.converter_on;
    assign o_level_limit  = r_out.level_limit;
    assign o_fired        = r_out.fired;
    assign o_busy_res     = r_out.busy;

    // Stall the input only with both stages full and the receiver holding off
    a_stall_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> (r_in_valid && r_out_valid && i_stall))
        else $error("input stalled while a stage is free");

    // A beat leaving the input stage must land in the result register
    a_move_lands: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        move |=> r_out_valid)
        else $error("processed beat lost");

    // A paused converter always belongs to an outstanding trigger
    a_pause_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_converter_on) |-> o_busy_res)
        else $error("converter paused with no trigger outstanding");

    // A detection happens only out of detector watch
    a_fire_channel: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_fired) |-> o_want_channel)
        else $error("fired while on background channel");

endmodule

[bench/adaptive_flash_trigger_controller_tb.sv]
`timescale 1ns / 100ps
// Self-checking bench for adaptive_flash_trigger_controller: a directed table, then random phases.
// Uses aftc_pkg and hdl/; every result beat is checked against the table or a local predictor.
module adaptive_flash_trigger_controller_tb;

    // Far above the length of any legal run
    localparam int CYCLE_LIMIT     = 200000;
    localparam int RANDOM_PHASES   = 9;
    localparam int BEATS_PER_PHASE = 105;
    localparam int STYLE_LOW       = 0;
    localparam int STYLE_HIGH      = 1;
    localparam int STYLE_MIX       = 2;
    localparam int SMP_W           = aftc_pkg::LIMIT_BITS;
    localparam int TICK_W          = aftc_pkg::TICK_BITS;
    localparam logic [2:0] UNMAPPED_REG = 3'd7;
    localparam logic [SMP_W-1:0] FULL_SCALE = '1;

    // Reports with the threshold still at full scale during the startup wait
    localparam aftc_pkg::t_result ACQUIRE_RPT = '{shutter: 1'b0, want_channel: 1'b0,
                                                  converter_on: 1'b1, level_limit: FULL_SCALE,
                                                  fired: 1'b0, busy: 1'b1};
    localparam aftc_pkg::t_result WATCH_RPT   = '{shutter: 1'b0, want_channel: 1'b1,
                                                  converter_on: 1'b1, level_limit: FULL_SCALE,
                                                  fired: 1'b0, busy: 1'b1};

    typedef struct {
        bit                 is_write;
        logic [2:0]         reg_sel;
        logic [TICK_W-1:0]  reg_val;
        aftc_pkg::t_req     kind;
        logic [SMP_W-1:0]   smp;
        bit                 typed;
        aftc_pkg::t_result  fixed_rpt;
    } t_plan_row;

    logic                             i_clk      = 1'b0;
    logic                             i_rst_n    = 1'b0;
    logic                             i_valid    = 1'b0;
    logic [1:0]                       i_req_type = aftc_pkg::REQ_TICK;
    logic [SMP_W-1:0]                 i_sample   = '0;
    logic                             i_stall    = 1'b0;
    logic                             psel       = 1'b0;
    logic                             penable    = 1'b0;
    logic                             pwrite     = 1'b0;
    logic [aftc_pkg::CFG_ADDR_W-1:0]  paddr      = '0;
    logic [aftc_pkg::APB_DATA_W-1:0]  pwdata     = '0;
    logic                             o_stall;
    logic                             o_valid;
    logic                             o_shutter;
    logic                             o_want_channel;
    logic                             o_converter_on;
    logic [SMP_W-1:0]                 o_level_limit;
    logic                             o_fired;
    logic                             o_busy_res;
    logic [aftc_pkg::APB_DATA_W-1:0]  prdata;
    logic                             pready;

    // Predictor state and its copy of the settings
    aftc_pkg::t_cfg          settings;
    aftc_pkg::t_mode         acq_mode;
    logic [12:0]             acc_sum;
    logic [3:0]              acc_count;
    logic [SMP_W-1:0]        trip_level;
    logic [TICK_W-1:0]       refresh_ticks;
    aftc_pkg::t_phase        seq_ph;
    logic [TICK_W-1:0]       seq_left;
    logic [TICK_W-1:0]       relock_left;
    logic                    relock_due;
    logic                    shot_pending;
    logic                    shutter_on;

    aftc_pkg::t_result trigger_reports_due[$];
    int      mismatch_count = 0;
    int      cycle_count    = 0;
    int      idle_pct       = 0;
    int      stall_pct      = 0;

    adaptive_flash_trigger_controller u_top (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_stall        (o_stall),
        .i_req_type     (i_req_type),
        .i_sample       (i_sample),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_shutter      (o_shutter),
        .o_want_channel (o_want_channel),
        .o_converter_on (o_converter_on),
        .o_level_limit  (o_level_limit),
        .o_fired        (o_fired),
        .o_busy_res     (o_busy_res),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    task automatic reset_predictor();
        settings.lockup_enable    = 1'b0;
        settings.refresh_interval = aftc_pkg::RST_REFRESH;
        settings.margin           = aftc_pkg::RST_MARGIN;
        settings.pulse_ticks      = aftc_pkg::RST_PULSE;
        settings.settle_ticks     = aftc_pkg::RST_SETTLE;
        settings.startup_ticks    = aftc_pkg::RST_STARTUP;
        settings.relock_timeout   = aftc_pkg::RST_RELOCK;
        acq_mode      = aftc_pkg::MODE_BG;
        acc_sum       = '0;
        acc_count     = '0;
        trip_level    = aftc_pkg::THRESHOLD_RST;
        refresh_ticks = '0;
        seq_ph        = aftc_pkg::PH_STARTUP;
        seq_left      = aftc_pkg::RST_STARTUP;
        relock_left   = '0;
        relock_due    = 1'b0;
        shot_pending  = 1'b0;
        shutter_on    = 1'b0;
    endtask

    task automatic begin_pulse(input aftc_pkg::t_phase ph);
        seq_ph     = ph;
        shutter_on = 1'b1;
        seq_left   = settings.pulse_ticks;
    endtask

    // Close out a shot: clear the pending flag, let a paused converter watch again, return to idle
    task automatic end_shot();
        shot_pending = 1'b0;
        if (acq_mode == aftc_pkg::MODE_OFF) begin
            acq_mode = aftc_pkg::MODE_DET;
        end
        seq_ph = aftc_pkg::PH_IDLE;
    endtask

    // Step the shutter sequencer until it waits on a timer or has nothing to do
    task automatic run_sequencer();
        bit settled;
        settled = 1'b0;
        while (!settled) begin
            if (seq_ph == aftc_pkg::PH_IDLE) begin
                if (shot_pending) begin
                    begin_pulse(aftc_pkg::PH_SHOT);
                end else if (settings.lockup_enable && relock_due) begin
                    relock_due = 1'b0;
                    begin_pulse(aftc_pkg::PH_RELOCK);
                end else begin
                    settled = 1'b1;
                end
            end else if (seq_left != '0) begin
                settled = 1'b1;
            end else begin
                case (seq_ph)
                    aftc_pkg::PH_STARTUP: begin
                        if (settings.lockup_enable) begin
                            begin_pulse(aftc_pkg::PH_INITLOCK);
                        end else begin
                            seq_ph = aftc_pkg::PH_IDLE;
                        end
                    end
                    aftc_pkg::PH_INITLOCK: begin
                        shutter_on = 1'b0;
                        seq_ph     = aftc_pkg::PH_IDLE;
                    end
                    aftc_pkg::PH_SHOT: begin
                        shutter_on = 1'b0;
                        if (settings.lockup_enable) begin
                            seq_ph   = aftc_pkg::PH_SETTLE;
                            seq_left = settings.settle_ticks;
                        end else begin
                            end_shot();
                        end
                    end
                    aftc_pkg::PH_SETTLE: begin
                        begin_pulse(aftc_pkg::PH_LOCK);
                    end
                    aftc_pkg::PH_LOCK: begin
                        shutter_on  = 1'b0;
                        relock_left = settings.relock_timeout;
                        end_shot();
                    end
                    default: begin
                        shutter_on  = 1'b0;
                        relock_left = settings.relock_timeout;
                        seq_ph      = aftc_pkg::PH_IDLE;
                    end
                endcase
            end
        end
    endtask

    // Advance the predictor by one accepted item and form its report
    task automatic apply_beat(input aftc_pkg::t_req kind, input logic [SMP_W-1:0] smp,
                              output aftc_pkg::t_result rpt);
        int level;
        bit hit;
        hit = 1'b0;
        case (kind)
            aftc_pkg::REQ_TICK: begin
                if (seq_left != '0) begin
                    seq_left = seq_left - 1'b1;
                end
                if (relock_left != '0) begin
                    relock_left = relock_left - 1'b1;
                    if (relock_left == '0) begin
                        relock_due = 1'b1;
                    end
                end
                if (refresh_ticks > settings.refresh_interval) begin
                    refresh_ticks = '0;
                    acq_mode      = aftc_pkg::MODE_BG;
                    acc_sum       = '0;
                    acc_count     = '0;
                end else begin
                    refresh_ticks = refresh_ticks + 1'b1;
                end
            end
            aftc_pkg::REQ_BG: begin
                if (acq_mode == aftc_pkg::MODE_BG) begin
                    acc_sum   = acc_sum + 13'(smp);
                    acc_count = acc_count + 1'b1;
                    if (acc_count >= aftc_pkg::AVG_SAMPLES) begin
                        level      = acc_sum / aftc_pkg::AVG_SAMPLES;
                        level      = level + int'(settings.margin);
                        trip_level = (level > FULL_SCALE) ? FULL_SCALE : level[SMP_W-1:0];
                        acc_sum    = '0;
                        acc_count  = '0;
                        acq_mode   = aftc_pkg::MODE_DET;
                    end
                end
            end
            aftc_pkg::REQ_DET: begin
                if (acq_mode == aftc_pkg::MODE_DET && smp > trip_level && !shot_pending) begin
                    shutter_on   = 1'b1;
                    acq_mode     = aftc_pkg::MODE_OFF;
                    shot_pending = 1'b1;
                    hit          = 1'b1;
                end
            end
            default: begin
            end
        endcase
        run_sequencer();
        rpt.shutter      = shutter_on;
        rpt.want_channel = (acq_mode != aftc_pkg::MODE_BG);
        rpt.converter_on = (acq_mode != aftc_pkg::MODE_OFF);
        rpt.level_limit  = trip_level;
        rpt.fired        = hit;
        rpt.busy         = shot_pending || (seq_ph != aftc_pkg::PH_IDLE);
    endtask

    // APB write: setup, access, then release the bus; mirror it in the predictor
    task automatic write_setting(input logic [2:0] idx, input logic [TICK_W-1:0] val);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= {16'd0, val};
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge i_clk);
        case (idx)
            aftc_pkg::REG_LOCKUP_EN: settings.lockup_enable    = val[0];
            aftc_pkg::REG_REFRESH:   settings.refresh_interval = val;
            aftc_pkg::REG_MARGIN:    settings.margin = val[aftc_pkg::MARGIN_BITS-1:0];
            aftc_pkg::REG_PULSE:     settings.pulse_ticks      = val;
            aftc_pkg::REG_SETTLE:    settings.settle_ticks     = val;
            aftc_pkg::REG_STARTUP: begin
                settings.startup_ticks = val;
                if (seq_ph == aftc_pkg::PH_STARTUP) begin
                    seq_left = val;
                end
            end
            aftc_pkg::REG_RELOCK:    settings.relock_timeout   = val;
            default: begin
            end
        endcase
    endtask

    // Drop valid and hold until every report has come back
    task automatic drain_results();
        i_valid <= 1'b0;
        while (trigger_reports_due.size() != 0) @(posedge i_clk);
        repeat (3) @(posedge i_clk);
    endtask

    task automatic send_beat(input aftc_pkg::t_req kind, input logic [SMP_W-1:0] smp,
                             input bit typed = 1'b0,
                             input aftc_pkg::t_result fixed_rpt = '0);
        aftc_pkg::t_result rpt;
        while ($urandom_range(0, 99) < idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid    <= 1'b1;
        i_req_type <= kind;
        i_sample   <= smp;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        apply_beat(kind, smp, rpt);
        trigger_reports_due.push_back(typed ? fixed_rpt : rpt);
    endtask

    function automatic t_plan_row beat_row(input aftc_pkg::t_req kind,
                                           input logic [SMP_W-1:0] smp,
                                           input bit typed = 1'b0,
                                           input aftc_pkg::t_result fixed_rpt = '0);
        t_plan_row row;
        row.is_write  = 1'b0;
        row.kind      = kind;
        row.smp       = smp;
        row.typed     = typed;
        row.fixed_rpt = fixed_rpt;
        return row;
    endfunction

    function automatic t_plan_row setting_row(input logic [2:0] idx,
                                              input logic [TICK_W-1:0] val);
        t_plan_row row;
        row.is_write = 1'b1;
        row.reg_sel  = idx;
        row.reg_val  = val;
        row.kind     = aftc_pkg::REQ_NONE;
        row.smp      = '0;
        row.typed    = 1'b0;
        return row;
    endfunction

    // Setting for one register: its lowest, its highest, or a random one, mostly small but startup
    function automatic logic [TICK_W-1:0] pick_value(input aftc_pkg::t_reg_idx idx,
                                                     input int style);
        int roll;
        roll = $urandom_range(0, 99);
        case (idx)
            aftc_pkg::REG_LOCKUP_EN: begin
                if (style == STYLE_LOW) return 16'd0;
                if (style == STYLE_HIGH) return 16'd1;
                return TICK_W'($urandom_range(0, 1));
            end
            aftc_pkg::REG_REFRESH: begin
                if (style == STYLE_LOW) return 16'd1;
                if (style == STYLE_HIGH || roll >= 90) return 16'hFFFF;
                return TICK_W'((roll < 75) ? $urandom_range(1, 80) : $urandom_range(1, 65535));
            end
            aftc_pkg::REG_MARGIN: begin
                if (style == STYLE_LOW) return 16'd0;
                if (style == STYLE_HIGH) return 16'd1023;
                return TICK_W'((roll < 80) ? $urandom_range(0, 60) : $urandom_range(0, 1023));
            end
            aftc_pkg::REG_PULSE: begin
                if (style == STYLE_LOW) return 16'd1;
                if (style == STYLE_HIGH) return 16'hFFFF;
                return TICK_W'((roll < 90) ? $urandom_range(1, 5) : $urandom_range(6, 40));
            end
            aftc_pkg::REG_SETTLE: begin
                if (style == STYLE_LOW) return 16'd0;
                if (style == STYLE_HIGH) return 16'hFFFF;
                return TICK_W'($urandom_range(0, 6));
            end
            aftc_pkg::REG_STARTUP: begin
                if (style == STYLE_LOW) return 16'd0;
                if (style == STYLE_HIGH) return 16'hFFFF;
                return TICK_W'($urandom_range(0, 65535));
            end
            default: begin
                if (style == STYLE_LOW) return 16'd0;
                if (style == STYLE_HIGH) return 16'hFFFF;
                return TICK_W'($urandom_range(0, 15));
            end
        endcase
    endfunction

    function automatic void check_field(input string label, input int unsigned want,
                                        input int unsigned got);
        if (want != got) begin
            $display("%0t: %s mismatch, expected %0d, got %0d", $time, label, want, got);
            mismatch_count++;
        end
    endfunction

    // Random stall on the result side
    always @(posedge i_clk) begin
        i_stall <= ($urandom_range(0, 99) < stall_pct);
    end

    // Compare each accepted result beat with the oldest report due
    always @(posedge i_clk) begin : watch_results
        aftc_pkg::t_result due;
        if (i_rst_n && o_valid && !i_stall) begin
            if (trigger_reports_due.size() == 0) begin
                $display("%0t: result beat with none due, expected nothing, got level %0d shot %0d",
                         $time, o_level_limit, o_shutter);
                mismatch_count++;
            end else begin
                due = trigger_reports_due.pop_front();
                check_field("shutter", 32'(due.shutter), 32'(o_shutter));
                check_field("want_channel", 32'(due.want_channel), 32'(o_want_channel));
                check_field("converter_on", 32'(due.converter_on), 32'(o_converter_on));
                check_field("level_limit", 32'(due.level_limit), 32'(o_level_limit));
                check_field("fired", 32'(due.fired), 32'(o_fired));
                check_field("busy_res", 32'(due.busy), 32'(o_busy_res));
            end
        end
    end

    // Stop a hung run
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("adaptive_flash_trigger_controller regression: fail");
            $finish;
        end
    end

    initial begin
        t_plan_row             plan[$];
        aftc_pkg::t_reg_idx    idx;
        aftc_pkg::t_req        kind;
        logic [SMP_W-1:0]      smp;
        int                    style;
        int                    pick;

        reset_predictor();

        // Defaults after reset: startup wait, background acquire, threshold at full scale
        plan.push_back(beat_row(aftc_pkg::REQ_TICK, 10'd0, 1'b1, ACQUIRE_RPT));
        plan.push_back(beat_row(aftc_pkg::REQ_NONE, 10'd1023, 1'b1, ACQUIRE_RPT));
        // Detector sample while acquiring background is ignored
        plan.push_back(beat_row(aftc_pkg::REQ_DET, 10'd1023, 1'b1, ACQUIRE_RPT));
        plan.push_back(beat_row(aftc_pkg::REQ_BG, 10'd1023, 1'b1, ACQUIRE_RPT));
        plan.push_back(setting_row(aftc_pkg::REG_MARGIN, 16'd1023));
        plan.push_back(setting_row(UNMAPPED_REG, 16'hFFFF));
        // Full-scale average plus full margin saturates the threshold
        for (int n = 0; n < 6; n++) begin
            plan.push_back(beat_row(aftc_pkg::REQ_BG, 10'd1023, 1'b1, ACQUIRE_RPT));
        end
        plan.push_back(beat_row(aftc_pkg::REQ_BG, 10'd1023, 1'b1, WATCH_RPT));
        // Equal to the threshold does not fire
        plan.push_back(beat_row(aftc_pkg::REQ_DET, 10'd1023, 1'b1, WATCH_RPT));
        // Shortest sequence; startup write during the startup wait reloads its timer
        plan.push_back(setting_row(aftc_pkg::REG_LOCKUP_EN, 16'd1));
        plan.push_back(setting_row(aftc_pkg::REG_STARTUP, 16'd0));
        plan.push_back(setting_row(aftc_pkg::REG_PULSE, 16'd1));
        plan.push_back(setting_row(aftc_pkg::REG_SETTLE, 16'd0));
        plan.push_back(setting_row(aftc_pkg::REG_RELOCK, 16'd1));
        plan.push_back(setting_row(aftc_pkg::REG_REFRESH, 16'd1));
        plan.push_back(setting_row(aftc_pkg::REG_MARGIN, 16'd0));
        plan.push_back(beat_row(aftc_pkg::REQ_TICK, 10'd0));
        plan.push_back(beat_row(aftc_pkg::REQ_TICK, 10'd1023));
        plan.push_back(beat_row(aftc_pkg::REQ_BG, 10'd512));
        for (int n = 0; n < 6; n++) begin
            plan.push_back(beat_row(aftc_pkg::REQ_BG, 10'd0));
        end
        plan.push_back(beat_row(aftc_pkg::REQ_BG, 10'd7));
        plan.push_back(beat_row(aftc_pkg::REQ_DET, 10'd64));
        plan.push_back(beat_row(aftc_pkg::REQ_DET, 10'd65));
        // Paused converter ignores detector samples
        plan.push_back(beat_row(aftc_pkg::REQ_DET, 10'd1023));
        plan.push_back(beat_row(aftc_pkg::REQ_TICK, 10'd0));
        plan.push_back(beat_row(aftc_pkg::REQ_TICK, 10'd0));

        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Walk the directed table
        foreach (plan[n]) begin
            if (plan[n].is_write) begin
                drain_results();
                write_setting(plan[n].reg_sel, plan[n].reg_val);
            end else begin
                send_beat(plan[n].kind, plan[n].smp, plan[n].typed, plan[n].fixed_rpt);
            end
        end

        // Random phases: lowest settings first, highest last, mixed in between
        for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
            drain_results();
            style = (ph == 0) ? STYLE_LOW : (ph == RANDOM_PHASES - 1) ? STYLE_HIGH : STYLE_MIX;
            idx = idx.first();
            do begin
                write_setting(idx, pick_value(idx, style));
                idx = idx.next();
            end while (idx != idx.first());
            case (ph % 4)
                0: begin idle_pct = 0;  stall_pct = 0;  end
                1: begin idle_pct = 67; stall_pct = 0;  end
                2: begin idle_pct = 0;  stall_pct = 67; end
                default: begin idle_pct = 35; stall_pct = 35; end
            endcase
            repeat (BEATS_PER_PHASE) begin
                pick = $urandom_range(0, 99);
                smp  = SMP_W'($urandom_range(0, 1023));
                if (pick < 45) begin
                    kind = aftc_pkg::REQ_TICK;
                end else if (pick < 72) begin
                    kind = aftc_pkg::REQ_BG;
                    // Keep most backgrounds low so detector samples can clear the threshold
                    if ($urandom_range(0, 3) != 0) smp = SMP_W'($urandom_range(0, 160));
                end else if (pick < 96) begin
                    kind = aftc_pkg::REQ_DET;
                end else begin
                    kind = aftc_pkg::REQ_NONE;
                end
                send_beat(kind, smp);
            end
        end

        i_valid <= 1'b0;
        while (trigger_reports_due.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
        if (mismatch_count == 0) begin
            $display("adaptive_flash_trigger_controller regression: pass");
        end else begin
            $display("adaptive_flash_trigger_controller regression: fail");
        end
        $finish;
    end

endmodule
